>>> src/e80d_pkg.sv
// Package for the extended-to-double converter: field widths and format constants.
// No dependencies.
`timescale 1ns / 1ps
package e80d_pkg;
    localparam int SeWidth   = 16;
    localparam int ManWidth  = 64;
    localparam int DblWidth  = 64;
    localparam logic [14:0] ExpAllOnes = 15'h7FFF;
    localparam logic [63:0] DblInf     = 64'h7FF0_0000_0000_0000;
    localparam int ExpOffset = 15423;
endpackage

>>> src/extended80_to_double.sv
// Converts an 80-bit extended value to an IEEE 754 binary64 bit pattern.
// Each beat passes the input register, then the output register.
// Throughput: one beat per cycle unless i_stall holds the output register.
// Reset (synchronous, active low) clears the valid flags of both registers.
// Uses e80d_pkg.
`timescale 1ns / 1ps
module extended80_to_double (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [e80d_pkg::SeWidth-1:0]  i_sign_and_exponent,
    input  logic [e80d_pkg::ManWidth-1:0] i_mantissa,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [e80d_pkg::DblWidth-1:0] o_double_bits
);
    logic        r_in_valid;
    logic [15:0] r_se;
    logic [63:0] r_man;
    logic        r_out_valid;
    logic [63:0] r_out;
    logic [63:0] n_out;
    logic        adv;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;

    logic [5:0]  lead;
    logic [63:0] norm;
    logic signed [17:0] d;
    logic signed [17:0] shf;
    logic [6:0]  sh;
    logic [63:0] kept, rem, half, mask;
    logic        rnd;
    logic [63:0] mag;

    always_comb begin
        lead = 6'd0;
        for (int k = 1; k < 64; k++) begin
            if (r_man[k]) begin
                lead = 6'(k);
            end
        end
        norm = r_man << (6'd63 - lead);
        d    = 18'($signed({3'b000, r_se[14:0]})) + 18'($signed({12'd0, lead}))
               - 18'(e80d_pkg::ExpOffset);
        shf  = (d >= 18'sd1) ? 18'sd11 : (18'sd12 - d);
        sh   = (shf > 18'sd64) ? 7'd65 : shf[6:0];
        if (sh >= 7'd64) begin
            kept = 64'd0;
            rem  = (sh == 7'd64) ? norm : 64'd0;
            half = 64'h8000_0000_0000_0000;
        end else begin
            mask = (64'd1 << sh[5:0]) - 64'd1;
            kept = norm >> sh[5:0];
            rem  = norm & mask;
            half = 64'd1 << (sh[5:0] - 6'd1);
        end
        mask = 64'd0;
        rnd  = (sh != 7'd65) && ((rem > half) || (rem == half && kept[0]));
        mag  = kept + {63'd0, rnd};
        if (d >= 18'sd1) begin
            mag = mag + {1'b0, d[10:0] - 11'd1, 52'd0};
        end
        if (r_se[14:0] == e80d_pkg::ExpAllOnes) begin
            n_out = {r_se[15], e80d_pkg::DblInf[62:0]};
        end else if (r_man == 64'd0) begin
            n_out = {r_se[15], 63'd0};
        end else if (d >= 18'sd2047) begin
            n_out = {r_se[15], e80d_pkg::DblInf[62:0]};
        end else begin
            n_out = {r_se[15], mag[62:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (!o_stall && i_valid) begin
            r_se  <= i_sign_and_exponent;
            r_man <= i_mantissa;
        end
        if (adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_double_bits = r_out;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_double_bits))
        else $error("result changed while stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv |=> o_valid)
        else $error("item lost between registers");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && o_valid)
        else $error("stall without full pipeline");
`endif
endmodule
